// ----- hw/rtl/fsp_pkg.sv -----
package fsp_pkg;

  // Parser modes
  typedef enum logic [2:0] {
    MODE_START  = 3'd0,
    MODE_HEADER = 3'd1,
    MODE_EOL    = 3'd2,
    MODE_SEQ    = 3'd3,
    MODE_DRAIN  = 3'd4
  } mode_t;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_RESIDUE = 2'd0,
    KIND_TERM    = 2'd1,
    KIND_REPORT  = 2'd2
  } kind_t;

  // Report status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_HEADER = 3'd1,
    ST_NO_DATA   = 3'd2,
    ST_CORRUPT   = 3'd3,
    ST_INVALID   = 3'd4,
    ST_EMPTY     = 3'd5,
    ST_LIMIT     = 3'd6,
    ST_OVERFLOW  = 3'd7
  } status_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_MASK_LO = 2'd0;
  localparam logic [1:0] CFG_MASK_HI = 2'd1;
  localparam logic [1:0] CFG_MIN_LEN = 2'd2;
  localparam logic [1:0] CFG_MAX_LEN = 2'd3;

  localparam int unsigned LEN_W = 31;

  // Character codes
  localparam logic [7:0] CH_GT = 8'h3E;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_SP = 8'h20;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LZ = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // One buffered result
  typedef struct packed {
    kind_t            kind;
    logic [6:0]       rbyte;
    status_t          status;
    logic [LEN_W-1:0] seq_count;
    logic [LEN_W-1:0] longest;
    logic             last;
  } res_ent_t;

endpackage

// ----- hw/rtl/fasta_sequence_parser_unit.sv -----
// FASTA parser: takes one file byte per transaction (last_byte flags the end of
// the file) and returns residues, sequence terminators and one final report.
// A byte goes through an input register and combinational decode into a
// three-entry result buffer, so its results are presented from that buffer
// once it has been loaded from the input register. A byte that gives zero or
// one result lets the block run at one byte per cycle on sequence data while
// the result port is ready; a byte that gives more results holds the input
// until the single result port drains the buffer. Configuration writes are
// always ready and should be made while idle.
module fasta_sequence_parser_unit #(
  parameter int unsigned TOTAL_LIMIT = 2147483647
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte input
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_value,
  input  logic        in_last_byte,
  // results
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_result_kind,
  output logic [6:0]  out_byte,
  output logic [2:0]  out_status,
  output logic [30:0] out_seq_count,
  output logic [30:0] out_longest_len,
  output logic        out_last_of_run,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int unsigned LW = fsp_pkg::LEN_W;
  localparam logic [LW:0] TOTAL_LIMIT_W = (LW+1)'(TOTAL_LIMIT);
  localparam logic [LW-1:0] LEN_MAX = '1;

  // configuration registers
  logic [63:0]   mask_lo_r, mask_hi_r;
  logic [LW-1:0] min_len_r, max_len_r;

  // parser state
  fsp_pkg::mode_t mode_r, mode_nxt;
  logic [LW-1:0]  seq_cnt_r, seq_cnt_nxt;
  logic [LW-1:0]  cur_len_r, cur_len_nxt;
  logic [LW-1:0]  longest_r, longest_nxt;
  logic [LW:0]    total_r, total_nxt;

  // input register
  logic       in_vld_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;

  // result buffer
  fsp_pkg::res_ent_t ent_r [3];
  fsp_pkg::res_ent_t ld    [3];
  logic [1:0]        cnt_r;
  logic [1:0]        n_ld;

  logic pop, can_load, proc;

  // decode
  logic [7:0]       up_c;
  logic             eol, is_gt, drop, corrupt, bad, seq_path, emit_res, do_close, close_ok;
  logic [127:0]     mask_all;
  logic [LW-1:0]    base_len, len_new, longest_base;
  logic [LW:0]      total_base;
  logic [LW+1:0]    sum;
  fsp_pkg::status_t close_st, fin_st;
  logic             fin_vld, term_vld;

  // handshakes
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && pop);
  assign proc      = in_vld_r && can_load;
  assign in_ready  = !in_vld_r || can_load;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_lo_r <= '0;
      mask_hi_r <= '0;
      min_len_r <= LW'(1);
      max_len_r <= LEN_MAX;
    end else if (cfg_valid) begin
      case (cfg_index)
        fsp_pkg::CFG_MASK_LO: mask_lo_r <= cfg_data;
        fsp_pkg::CFG_MASK_HI: mask_hi_r <= cfg_data;
        fsp_pkg::CFG_MIN_LEN: min_len_r <= cfg_data[LW-1:0];
        fsp_pkg::CFG_MAX_LEN: max_len_r <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte_value;
      in_last_r <= in_last_byte;
    end
  end

  // byte classification
  assign up_c     = (in_byte_r >= fsp_pkg::CH_LA && in_byte_r <= fsp_pkg::CH_LZ) ?
                    in_byte_r - fsp_pkg::CASE_OFS : in_byte_r;
  assign eol      = (in_byte_r == fsp_pkg::CH_CR) || (in_byte_r == fsp_pkg::CH_LF);
  assign is_gt    = (in_byte_r == fsp_pkg::CH_GT);
  assign drop     = (up_c == fsp_pkg::CH_CR) || (up_c == fsp_pkg::CH_LF) ||
                    (up_c == fsp_pkg::CH_SP);
  assign mask_all = {mask_hi_r, mask_lo_r};
  assign corrupt  = !is_gt && !drop && ((up_c == 8'd0) || up_c[7]);
  assign bad      = !is_gt && !drop && !corrupt && !mask_all[up_c[6:0]];
  assign seq_path = (mode_r == fsp_pkg::MODE_SEQ) ||
                    ((mode_r == fsp_pkg::MODE_EOL) && !eol);
  assign emit_res = seq_path && !is_gt && !drop && !corrupt && !bad;

  // lengths and totals, with the file counters cleared at start of file
  assign base_len     = (mode_r == fsp_pkg::MODE_EOL) ? '0 : cur_len_r;
  assign len_new      = (emit_res && base_len != LEN_MAX) ? base_len + LW'(1) : base_len;
  assign longest_base = (mode_r == fsp_pkg::MODE_START) ? '0 : longest_r;
  assign total_base   = (mode_r == fsp_pkg::MODE_START) ? '0 : total_r;
  assign sum          = {1'b0, total_base} + (LW+2)'(len_new) + (LW+2)'(1);

  // sequence close checks
  always_comb begin
    if (len_new == '0) begin
      close_st = fsp_pkg::ST_EMPTY;
    end else if (len_new < min_len_r || len_new > max_len_r) begin
      close_st = fsp_pkg::ST_LIMIT;
    end else if (sum > {1'b0, TOTAL_LIMIT_W}) begin
      close_st = fsp_pkg::ST_OVERFLOW;
    end else begin
      close_st = fsp_pkg::ST_OK;
    end
  end
  assign close_ok = (close_st == fsp_pkg::ST_OK);
  assign do_close = seq_path && (is_gt || (in_last_r && !corrupt && !bad));

  // terminator and final report decisions
  always_comb begin
    fin_vld  = 1'b0;
    fin_st   = fsp_pkg::ST_OK;
    term_vld = 1'b0;
    case (mode_r)
      fsp_pkg::MODE_START: begin
        if (!is_gt) begin
          fin_vld = 1'b1;
          fin_st  = fsp_pkg::ST_NO_HEADER;
        end else if (in_last_r) begin
          fin_vld = 1'b1;
          fin_st  = fsp_pkg::ST_NO_DATA;
        end
      end
      fsp_pkg::MODE_HEADER: begin
        if (in_last_r) begin
          fin_vld = 1'b1;
          fin_st  = fsp_pkg::ST_NO_DATA;
        end
      end
      fsp_pkg::MODE_EOL: begin
        if (eol && in_last_r) begin
          fin_vld = 1'b1;
          fin_st  = fsp_pkg::ST_NO_DATA;
        end
      end
      default: ;
    endcase
    if (seq_path) begin
      if (is_gt) begin
        if (close_ok) begin
          term_vld = 1'b1;
          if (in_last_r) begin
            fin_vld = 1'b1;
            fin_st  = fsp_pkg::ST_NO_DATA;
          end
        end else begin
          fin_vld = 1'b1;
          fin_st  = close_st;
        end
      end else if (corrupt) begin
        fin_vld = 1'b1;
        fin_st  = fsp_pkg::ST_CORRUPT;
      end else if (bad) begin
        fin_vld = 1'b1;
        fin_st  = fsp_pkg::ST_INVALID;
      end else if (in_last_r) begin
        fin_vld  = 1'b1;
        term_vld = close_ok;
        fin_st   = close_st;
      end
    end
  end

  // next mode
  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      fsp_pkg::MODE_START:  mode_nxt = fsp_pkg::MODE_HEADER;
      fsp_pkg::MODE_HEADER: if (eol) mode_nxt = fsp_pkg::MODE_EOL;
      fsp_pkg::MODE_EOL:    if (!eol) mode_nxt = fsp_pkg::MODE_SEQ;
      fsp_pkg::MODE_SEQ:    ;
      default:              if (in_last_r) mode_nxt = fsp_pkg::MODE_START;
    endcase
    if (seq_path && is_gt && close_ok) mode_nxt = fsp_pkg::MODE_HEADER;
    if (fin_vld) mode_nxt = in_last_r ? fsp_pkg::MODE_START : fsp_pkg::MODE_DRAIN;
  end

  // next counters
  always_comb begin
    seq_cnt_nxt = seq_cnt_r;
    if (mode_r == fsp_pkg::MODE_START) begin
      seq_cnt_nxt = '0;
    end else if (mode_r == fsp_pkg::MODE_EOL && !eol) begin
      seq_cnt_nxt = seq_cnt_r + LW'(1);
    end
    if (seq_path) begin
      cur_len_nxt = len_new;
    end else if (mode_r == fsp_pkg::MODE_START) begin
      cur_len_nxt = '0;
    end else begin
      cur_len_nxt = cur_len_r;
    end
    longest_nxt = longest_base;
    total_nxt   = total_base;
    if (do_close && close_ok) begin
      if (len_new > longest_base) longest_nxt = len_new;
      total_nxt = sum[LW:0];
    end
  end

  // gather the results of this byte in order: residue, terminator, report
  always_comb begin
    fsp_pkg::res_ent_t sl [3];
    logic [2:0]        sv;
    logic [1:0]        pos;
    sl[0].kind      = fsp_pkg::KIND_RESIDUE;
    sl[0].rbyte     = up_c[6:0];
    sl[0].status    = fsp_pkg::ST_OK;
    sl[0].seq_count = seq_cnt_nxt;
    sl[0].longest   = longest_base;
    sl[0].last      = !term_vld && !fin_vld;
    sl[1].kind      = fsp_pkg::KIND_TERM;
    sl[1].rbyte     = '0;
    sl[1].status    = fsp_pkg::ST_OK;
    sl[1].seq_count = seq_cnt_nxt;
    sl[1].longest   = longest_nxt;
    sl[1].last      = !fin_vld;
    sl[2].kind      = fsp_pkg::KIND_REPORT;
    sl[2].rbyte     = '0;
    sl[2].status    = fin_st;
    sl[2].seq_count = seq_cnt_nxt;
    sl[2].longest   = longest_nxt;
    sl[2].last      = 1'b1;
    sv  = {fin_vld, term_vld, emit_res};
    pos = '0;
    for (int i = 0; i < 3; i++) begin
      ld[i] = sl[2];
    end
    for (int i = 0; i < 3; i++) begin
      if (sv[i]) begin
        ld[pos] = sl[i];
        pos     = pos + 2'd1;
      end
    end
    n_ld = pos;
  end

  // parser state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= fsp_pkg::MODE_START;
      seq_cnt_r <= '0;
      cur_len_r <= '0;
      longest_r <= '0;
      total_r   <= '0;
    end else if (proc) begin
      mode_r    <= mode_nxt;
      seq_cnt_r <= seq_cnt_nxt;
      cur_len_r <= cur_len_nxt;
      longest_r <= longest_nxt;
      total_r   <= total_nxt;
    end
  end

  // result buffer: load a whole run, or shift one out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (proc) begin
      cnt_r <= n_ld;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      for (int i = 0; i < 3; i++) ent_r[i] <= ld[i];
    end else if (pop) begin
      ent_r[0] <= ent_r[1];
      ent_r[1] <= ent_r[2];
    end
  end

  // output port
  assign out_valid       = (cnt_r != 2'd0);
  assign out_result_kind = ent_r[0].kind;
  assign out_byte        = ent_r[0].rbyte;
  assign out_status      = ent_r[0].status;
  assign out_seq_count   = ent_r[0].seq_count;
  assign out_longest_len = ent_r[0].longest;
  assign out_last_of_run = ent_r[0].last;

  // checks
  a_report_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == fsp_pkg::KIND_REPORT |-> out_last_of_run)
    else $error("report not last of its run");

  a_residue_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == fsp_pkg::KIND_RESIDUE |->
      out_status == fsp_pkg::ST_OK && out_byte != 7'd0)
    else $error("residue with status or zero code");

  a_term_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == fsp_pkg::KIND_TERM |->
      out_byte == 7'd0 && out_status == fsp_pkg::ST_OK)
    else $error("terminator with data");

  a_buf_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3 || (!in_vld_r || !can_load))
    else $error("byte taken into a full result buffer");

  a_drain_silent: assert property (@(posedge clk) disable iff (!rst_n)
    proc && mode_r == fsp_pkg::MODE_DRAIN |=> cnt_r == 2'd0)
    else $error("result produced while dropping after error");

endmodule

// ----- dv/fasta_sequence_parser_unit_test.sv -----
module fasta_sequence_parser_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned TOTAL_LIMIT = 2147483647;
  localparam int SETTLE_CYCLES = 8;
  localparam int LONG_HOLD = 400;
  localparam int PHASE_BYTES = 30;
  localparam logic [30:0] LEN_MAX = 31'h7FFF_FFFF;
  // 'A'..'Z' in the upper mask, '*' and '-' in the lower one
  localparam logic [63:0] LETTERS_HI = 64'h0000_0000_07FF_FFFE;
  localparam logic [63:0] PUNCT_LO = 64'h0000_2400_0000_0000;

  typedef struct packed {
    logic [7:0] b;
    logic       lst;
  } file_byte_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte_value = '0;
  logic        in_last_byte = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_result_kind;
  logic [6:0]  out_byte;
  logic [2:0]  out_status;
  logic [30:0] out_seq_count;
  logic [30:0] out_longest_len;
  logic        out_last_of_run;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // Byte stream waiting to be offered, and results still owed by the block
  file_byte_t          byte_q[$];
  fsp_pkg::res_ent_t   expected[$];
  int                  bytes_queued = 0;
  int                  bytes_taken = 0;
  int                  err_count = 0;

  // Stimulus knobs set by the sequencing block
  bit          no_gaps = 1'b0;
  int          hold_req = 0;

  // Configuration mirror
  logic [63:0] mask_lo = '0;
  logic [63:0] mask_hi = '0;
  logic [30:0] min_len = 31'd1;
  logic [30:0] max_len = LEN_MAX;

  // Parser state mirror
  fsp_pkg::mode_t pmode = fsp_pkg::MODE_START;
  logic [30:0]    seqs = '0;
  logic [30:0]    cur_len = '0;
  logic [30:0]    longest = '0;
  logic [31:0]    total = '0;

  int                tx_gap = 0;
  int                rx_stall = 0;
  int                hold_done = 0;
  file_byte_t        tx_next;
  fsp_pkg::res_ent_t rx_want;

  fasta_sequence_parser_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte_value   (in_byte_value),
    .in_last_byte    (in_last_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_byte        (out_byte),
    .out_status      (out_status),
    .out_seq_count   (out_seq_count),
    .out_longest_len (out_longest_len),
    .out_last_of_run (out_last_of_run),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always #5 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic flag_mismatch(input string what, input longint unsigned want_v,
                               input longint unsigned got_v);
    $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want_v, got_v);
    err_count++;
  endtask

  function automatic fsp_pkg::res_ent_t make_res(input fsp_pkg::kind_t k,
                                                 input logic [6:0] rb,
                                                 input fsp_pkg::status_t st);
    fsp_pkg::res_ent_t r;
    r.kind = k;
    r.rbyte = rb;
    r.status = st;
    r.seq_count = seqs;
    r.longest = longest;
    r.last = 1'b0;
    return r;
  endfunction

  // Close the open sequence; 1 when it passes, otherwise st holds the error
  function automatic logic close_seq(output fsp_pkg::status_t st);
    logic [32:0] sum;
    sum = {1'b0, total} + cur_len + 33'd1;
    st = fsp_pkg::ST_OK;
    if (cur_len == '0) begin
      st = fsp_pkg::ST_EMPTY;
    end else if (cur_len < min_len || cur_len > max_len) begin
      st = fsp_pkg::ST_LIMIT;
    end else if (sum > TOTAL_LIMIT) begin
      st = fsp_pkg::ST_OVERFLOW;
    end else begin
      if (cur_len > longest) longest = cur_len;
      total = sum[31:0];
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Predict the results of one accepted byte and queue them
  task automatic parse_byte(input logic [7:0] b, input logic lst);
    fsp_pkg::res_ent_t run [3];
    int                n;
    logic              eol;
    logic              in_seq;
    logic              have_report;
    fsp_pkg::status_t  rep_st;
    fsp_pkg::status_t  cl_st;
    logic [7:0]        c;
    n = 0;
    eol = (b == fsp_pkg::CH_CR || b == fsp_pkg::CH_LF);
    in_seq = 1'b0;
    have_report = 1'b0;
    rep_st = fsp_pkg::ST_OK;
    case (pmode)
      fsp_pkg::MODE_START: begin
        seqs = '0;
        cur_len = '0;
        longest = '0;
        total = '0;
        if (b != fsp_pkg::CH_GT) begin
          have_report = 1'b1;
          rep_st = fsp_pkg::ST_NO_HEADER;
        end else begin
          pmode = fsp_pkg::MODE_HEADER;
          if (lst) begin
            have_report = 1'b1;
            rep_st = fsp_pkg::ST_NO_DATA;
          end
        end
      end
      fsp_pkg::MODE_HEADER: begin
        if (eol) pmode = fsp_pkg::MODE_EOL;
        if (lst) begin
          have_report = 1'b1;
          rep_st = fsp_pkg::ST_NO_DATA;
        end
      end
      fsp_pkg::MODE_EOL: begin
        if (eol) begin
          if (lst) begin
            have_report = 1'b1;
            rep_st = fsp_pkg::ST_NO_DATA;
          end
        end else begin
          seqs = seqs + 31'd1;
          cur_len = '0;
          pmode = fsp_pkg::MODE_SEQ;
          in_seq = 1'b1;
        end
      end
      fsp_pkg::MODE_SEQ: in_seq = 1'b1;
      default: begin
        // dropping after an error until the file ends
        if (lst) pmode = fsp_pkg::MODE_START;
      end
    endcase

    if (in_seq) begin
      if (b == fsp_pkg::CH_GT) begin
        if (close_seq(cl_st)) begin
          run[n] = make_res(fsp_pkg::KIND_TERM, 7'd0, fsp_pkg::ST_OK);
          n++;
          pmode = fsp_pkg::MODE_HEADER;
          if (lst) begin
            have_report = 1'b1;
            rep_st = fsp_pkg::ST_NO_DATA;
          end
        end else begin
          have_report = 1'b1;
          rep_st = cl_st;
        end
      end else begin
        c = (b >= fsp_pkg::CH_LA && b <= fsp_pkg::CH_LZ) ? b - fsp_pkg::CASE_OFS : b;
        if (c == fsp_pkg::CH_CR || c == fsp_pkg::CH_LF || c == fsp_pkg::CH_SP) begin
          // whitespace inside a sequence is dropped
        end else if (c == 8'd0 || c > 8'd127) begin
          have_report = 1'b1;
          rep_st = fsp_pkg::ST_CORRUPT;
        end else if (!(c < 8'd64 ? mask_lo[c[5:0]] : mask_hi[c[5:0]])) begin
          have_report = 1'b1;
          rep_st = fsp_pkg::ST_INVALID;
        end else begin
          run[n] = make_res(fsp_pkg::KIND_RESIDUE, c[6:0], fsp_pkg::ST_OK);
          n++;
          if (cur_len != LEN_MAX) cur_len = cur_len + 31'd1;
        end
        if (!have_report && lst) begin
          have_report = 1'b1;
          if (close_seq(cl_st)) begin
            run[n] = make_res(fsp_pkg::KIND_TERM, 7'd0, fsp_pkg::ST_OK);
            n++;
            rep_st = fsp_pkg::ST_OK;
          end else begin
            rep_st = cl_st;
          end
        end
      end
    end

    if (have_report) begin
      run[n] = make_res(fsp_pkg::KIND_REPORT, 7'd0, rep_st);
      n++;
      if (lst) pmode = fsp_pkg::MODE_START;
      else pmode = fsp_pkg::MODE_DRAIN;
    end
    for (int i = 0; i < n; i++) begin
      run[i].last = (i == n - 1);
      expected.push_back(run[i]);
    end
  endtask

  // Configuration mirror follows each accepted write transaction
  always @(posedge clk) begin
    if (!rst_n) begin
      mask_lo = '0;
      mask_hi = '0;
      min_len = 31'd1;
      max_len = LEN_MAX;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fsp_pkg::CFG_MASK_LO: mask_lo = cfg_data;
        fsp_pkg::CFG_MASK_HI: mask_hi = cfg_data;
        fsp_pkg::CFG_MIN_LEN: min_len = cfg_data[30:0];
        fsp_pkg::CFG_MAX_LEN: max_len = cfg_data[30:0];
        default: begin end
      endcase
    end
  end

  // Byte driver: predicts on acceptance, then offers the next byte after a gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
      pmode = fsp_pkg::MODE_START;
      seqs = '0;
      cur_len = '0;
      longest = '0;
      total = '0;
    end else begin
      if (in_valid && in_ready) begin
        parse_byte(in_byte_value, in_last_byte);
        bytes_taken++;
      end
      if (in_valid && !in_ready) begin
        // hold the transaction until taken
      end else if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (byte_q.size() != 0) begin
        tx_next = byte_q.pop_front();
        in_valid <= 1'b1;
        in_byte_value <= tx_next.b;
        in_last_byte <= tx_next.lst;
        tx_gap = pick_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor: checks each transaction against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected.size() == 0) begin
          flag_mismatch("unexpected result kind", 0, out_result_kind);
        end else begin
          rx_want = expected.pop_front();
          if (out_result_kind !== rx_want.kind)
            flag_mismatch("result_kind", rx_want.kind, out_result_kind);
          if (out_byte !== rx_want.rbyte)
            flag_mismatch("out_byte", rx_want.rbyte, out_byte);
          if (out_status !== rx_want.status)
            flag_mismatch("status", rx_want.status, out_status);
          if (out_seq_count !== rx_want.seq_count)
            flag_mismatch("seq_count", rx_want.seq_count, out_seq_count);
          if (out_longest_len !== rx_want.longest)
            flag_mismatch("longest_len", rx_want.longest, out_longest_len);
          if (out_last_of_run !== rx_want.last)
            flag_mismatch("last_of_run", rx_want.last, out_last_of_run);
        end
      end
      if (hold_done != hold_req) begin
        hold_done = hold_req;
        rx_stall = LONG_HOLD;
      end
      if (rx_stall > 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        rx_stall = pick_gap();
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic lst);
    file_byte_t fb;
    fb.b = b;
    fb.lst = lst;
    byte_q.push_back(fb);
    bytes_queued++;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [63:0] lo, input logic [63:0] hi,
                            input logic [30:0] mn, input logic [30:0] mx);
    write_reg(fsp_pkg::CFG_MASK_LO, lo);
    write_reg(fsp_pkg::CFG_MASK_HI, hi);
    write_reg(fsp_pkg::CFG_MIN_LEN, {33'd0, mn});
    write_reg(fsp_pkg::CFG_MAX_LEN, {33'd0, mx});
  endtask

  // Wait for every byte to be taken and every result to arrive, then settle
  task automatic wait_drained();
    do @(posedge clk); while (bytes_taken != bytes_queued || expected.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One random file: mostly well-formed records, sometimes plain noise
  task automatic gen_file();
    logic [7:0] fb [$];
    logic [7:0] b;
    int recs;
    int len;
    int r;
    if ($urandom_range(0, 5) == 0) begin
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) fb.push_back(8'($urandom_range(0, 255)));
    end else begin
      recs = $urandom_range(1, 3);
      for (int k = 0; k < recs; k++) begin
        fb.push_back(fsp_pkg::CH_GT);
        len = $urandom_range(0, 4);
        for (int i = 0; i < len; i++) begin
          do b = 8'($urandom_range(0, 255));
          while (b == fsp_pkg::CH_CR || b == fsp_pkg::CH_LF);
          fb.push_back(b);
        end
        len = $urandom_range(1, 2);
        for (int i = 0; i < len; i++)
          fb.push_back($urandom_range(0, 1) ? fsp_pkg::CH_CR : fsp_pkg::CH_LF);
        len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 9);
        for (int i = 0; i < len; i++) begin
          r = $urandom_range(0, 99);
          if (r < 70) b = 8'h41 + 8'($urandom_range(0, 25));
          else if (r < 85) b = fsp_pkg::CH_LA + 8'($urandom_range(0, 25));
          else if (r < 90) b = $urandom_range(0, 1) ? 8'h2A : 8'h2D;
          else if (r < 95)
            b = ($urandom_range(0, 2) == 0) ? fsp_pkg::CH_SP : fsp_pkg::CH_LF;
          else b = 8'($urandom_range(0, 255));
          fb.push_back(b);
        end
      end
    end
    foreach (fb[i]) push_byte(fb[i], i == fb.size() - 1);
  endtask

  task automatic run_files(input int n_bytes);
    int start;
    start = bytes_queued;
    while (bytes_queued - start < n_bytes) gen_file();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    set_config(PUNCT_LO, LETTERS_HI, 31'd1, LEN_MAX);

    // Directed: no header, then dropping up to the last byte
    push_byte("A", 1'b0);
    push_byte("B", 1'b1);
    // header that is also the last byte
    push_byte(fsp_pkg::CH_GT, 1'b1);
    // two records, lower case, whitespace, close by '>' and by end of file
    push_byte(fsp_pkg::CH_GT, 1'b0);
    push_byte("h", 1'b0);
    push_byte(fsp_pkg::CH_CR, 1'b0);
    push_byte(fsp_pkg::CH_LF, 1'b0);
    push_byte("a", 1'b0);
    push_byte("C", 1'b0);
    push_byte(fsp_pkg::CH_SP, 1'b0);
    push_byte(fsp_pkg::CH_LF, 1'b0);
    push_byte("g", 1'b0);
    push_byte(fsp_pkg::CH_GT, 1'b0);
    push_byte(fsp_pkg::CH_LF, 1'b0);
    push_byte("t", 1'b1);
    // zero byte is corrupt; a high byte is then dropped
    push_byte(fsp_pkg::CH_GT, 1'b0);
    push_byte(fsp_pkg::CH_LF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b1);
    // empty sequence closed by '>'
    push_byte(fsp_pkg::CH_GT, 1'b0);
    push_byte(fsp_pkg::CH_LF, 1'b0);
    push_byte(fsp_pkg::CH_GT, 1'b1);
    // character outside the mask
    push_byte(fsp_pkg::CH_GT, 1'b0);
    push_byte(fsp_pkg::CH_LF, 1'b0);
    push_byte(8'h23, 1'b1);
    wait_drained();

    // back-to-back stretch with no idling on either side
    no_gaps = 1'b1;
    run_files(PHASE_BYTES);
    wait_drained();
    no_gaps = 1'b0;

    // tight length window, receiver holds off while bytes keep coming
    set_config(PUNCT_LO, LETTERS_HI, 31'd3, 31'd12);
    run_files(PHASE_BYTES);
    hold_req++;
    wait_drained();

    // every mask bit set, only single-residue sequences pass
    set_config('1, '1, 31'd1, 31'd1);
    run_files(PHASE_BYTES);
    wait_drained();

    // random masks, minimum at its top so every non-empty sequence fails the limit
    set_config({$urandom, $urandom} | PUNCT_LO, {$urandom, $urandom} | LETTERS_HI,
               LEN_MAX, LEN_MAX);
    run_files(PHASE_BYTES);
    wait_drained();

    // letters only, punctuation now invalid
    set_config('0, LETTERS_HI, 31'd2, 31'd20);
    run_files(PHASE_BYTES);
    hold_req++;
    wait_drained();

    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
